// ----- src/mcht_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mcht_pkg;

  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 11;

  localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  // One stored line: y = slope*x + intercept.
  typedef struct packed {
    logic signed [31:0] intercept;
    logic signed [31:0] slope;
  } line_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_CHECK,
    S_ADD_MUL_L,
    S_ADD_MUL_R,
    S_ADD_CMP,
    S_ADD_FIN,
    S_Q_LOOP,
    S_Q_MID,
    S_Q_NEXT,
    S_Q_CMP,
    S_Q_FIN_MUL,
    S_Q_FIN_ADD,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// ----- src/monotone_convex_hull_trick_unit.sv -----
// Lower envelope of lines for minimum queries (monotone convex hull trick).
// Input channel s_*: s_tuser carries the op (add line, query, clear) and
// s_tdata the slope, intercept and query abscissa. Output channel m_*: one
// result per request, m_tdata with the minimum value and line count, m_tuser
// with the status. A request is taken when tvalid and tready are both high.
// The unit handles one request at a time; s_tready is high only when idle.
// Work per request, with n lines stored: a clear, an unused op or a query
// on an empty envelope goes straight to the result register; an add checks
// the top line against the line below it, pops each line found covered and
// then pushes or merges the new line;
// a query takes s search steps, at most ceil(log2 n), each with two stack
// reads and two products through the one shared multiplier, and then forms
// the value of the line that it found.
// The single stack read port and the shared multiplier serialise this work.
// The result waits in an output register; the next request is accepted and
// worked on while a stalled receiver holds m_tready low, and the unit only
// waits when a second result is ready before the first has left.
// Reset (rst, synchronous) empties the envelope and drops any pending result;
// stack memory contents are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module monotone_convex_hull_trick_unit #(
  parameter int HULL_DEPTH = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [95:0] s_tdata,   // line_slope, line_intercept, query_x
  input  wire logic [1:0]  s_tuser,   // op
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [79:0]      m_tdata,   // min_value, line_count, zero fill
  output logic [1:0]       m_tuser    // status
);

  localparam int AW = (HULL_DEPTH > 1) ? $clog2(HULL_DEPTH) : 1;
  localparam int CW = $clog2(HULL_DEPTH + 1);

  mcht_pkg::state_t state, state_next;

  logic [CW-1:0]                  count;
  mcht_pkg::line_t                top_line;
  mcht_pkg::line_t                s2_line;
  mcht_pkg::line_t                new_line;
  logic [mcht_pkg::OP_W-1:0]      op_r;
  logic signed [31:0]             qx;
  logic [AW-1:0]                  lo, hi, mid;
  logic signed [31:0]             b_hold, b_nx;
  logic signed [63:0]             val_mid;
  logic signed [65:0]             lprod;
  logic [63:0]                    res_value;
  logic [mcht_pkg::STATUS_W-1:0]  res_status;

  logic                mem_we;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  mcht_pkg::line_t     mem_wdata, mem_rdata;
  logic signed [32:0]  mul_a, mul_b;
  logic signed [65:0]  prod;

  logic                pop_check;
  logic                redundant;
  logic                same_slope;
  logic                is_full;
  logic [AW:0]         mid_sum;
  logic [AW-1:0]       mid_c;
  logic signed [63:0]  val_nx;
  logic signed [63:0]  val_fin;
  logic                out_free;

  mcht_stack_mem #(
    .DEPTH(HULL_DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  mcht_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .prod(prod)
  );

  assign s_tready   = (state == mcht_pkg::S_IDLE);
  assign out_free   = !m_tvalid || m_tready;
  assign pop_check  = (count >= CW'(2)) && (top_line.slope <= new_line.slope);
  assign redundant  = (lprod <= prod);
  assign same_slope = (count != '0) && (top_line.slope == new_line.slope);
  assign is_full    = (count == CW'(HULL_DEPTH));
  assign mid_sum    = {1'b0, lo} + {1'b0, hi};
  assign mid_c      = mid_sum[AW:1];
  assign val_nx     = prod[63:0] + 64'(b_nx);
  assign val_fin    = prod[63:0] + 64'(b_hold);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      mcht_pkg::S_IDLE: begin
        if (s_tvalid) begin
          if (s_tuser == mcht_pkg::OP_ADD) begin
            state_next = mcht_pkg::S_ADD_CHECK;
          end else if (s_tuser == mcht_pkg::OP_QUERY && count != '0) begin
            state_next = mcht_pkg::S_Q_LOOP;
          end else begin
            state_next = mcht_pkg::S_DONE;
          end
        end
      end
      mcht_pkg::S_ADD_CHECK: begin
        state_next = pop_check ? mcht_pkg::S_ADD_MUL_L : mcht_pkg::S_ADD_FIN;
      end
      mcht_pkg::S_ADD_MUL_L: state_next = mcht_pkg::S_ADD_MUL_R;
      mcht_pkg::S_ADD_MUL_R: state_next = mcht_pkg::S_ADD_CMP;
      mcht_pkg::S_ADD_CMP: begin
        state_next = redundant ? mcht_pkg::S_ADD_CHECK : mcht_pkg::S_ADD_FIN;
      end
      mcht_pkg::S_ADD_FIN: state_next = mcht_pkg::S_DONE;
      mcht_pkg::S_Q_LOOP: begin
        state_next = (lo == hi) ? mcht_pkg::S_Q_FIN_MUL : mcht_pkg::S_Q_MID;
      end
      mcht_pkg::S_Q_MID:     state_next = mcht_pkg::S_Q_NEXT;
      mcht_pkg::S_Q_NEXT:    state_next = mcht_pkg::S_Q_CMP;
      mcht_pkg::S_Q_CMP:     state_next = mcht_pkg::S_Q_LOOP;
      mcht_pkg::S_Q_FIN_MUL: state_next = mcht_pkg::S_Q_FIN_ADD;
      mcht_pkg::S_Q_FIN_ADD: state_next = mcht_pkg::S_DONE;
      mcht_pkg::S_DONE: begin
        if (out_free) begin
          state_next = mcht_pkg::S_IDLE;
        end
      end
      default: state_next = mcht_pkg::S_IDLE;
    endcase
  end

  // Memory port and multiplier operand selection.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = AW'(count);
    mem_wdata = new_line;
    mem_raddr = lo;
    mul_a     = 33'(top_line.intercept) - 33'(new_line.intercept);
    mul_b     = 33'(top_line.slope) - 33'(s2_line.slope);
    case (state)
      mcht_pkg::S_ADD_CHECK: begin
        mem_raddr = AW'(count - CW'(2));
      end
      mcht_pkg::S_ADD_MUL_L: begin
        mul_a = 33'(mem_rdata.intercept) - 33'(top_line.intercept);
        mul_b = 33'(new_line.slope) - 33'(top_line.slope);
      end
      mcht_pkg::S_ADD_FIN: begin
        if (same_slope) begin
          // Equal slope: only a lower intercept replaces the top line.
          mem_we    = (new_line.intercept < top_line.intercept);
          mem_waddr = AW'(count - CW'(1));
        end else begin
          mem_we = !is_full;
        end
      end
      mcht_pkg::S_Q_LOOP: begin
        mem_raddr = (lo == hi) ? lo : mid_c;
      end
      mcht_pkg::S_Q_MID: begin
        mem_raddr = mid + AW'(1);
        mul_a     = 33'(mem_rdata.slope);
        mul_b     = 33'(qx);
      end
      mcht_pkg::S_Q_NEXT, mcht_pkg::S_Q_FIN_MUL: begin
        mul_a = 33'(mem_rdata.slope);
        mul_b = 33'(qx);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mcht_pkg::S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      case (state)
        mcht_pkg::S_IDLE: begin
          if (s_tvalid && s_tuser == mcht_pkg::OP_CLEAR) begin
            count <= '0;
          end
        end
        mcht_pkg::S_ADD_CMP: begin
          if (redundant) begin
            count <= count - CW'(1);
          end
        end
        mcht_pkg::S_ADD_FIN: begin
          if (!same_slope && !is_full) begin
            count <= count + CW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      mcht_pkg::S_IDLE: begin
        new_line.slope     <= s_tdata[31:0];
        new_line.intercept <= s_tdata[63:32];
        qx                 <= s_tdata[95:64];
        op_r               <= s_tuser;
        lo                 <= '0;
        hi                 <= AW'(count - CW'(1));
        res_value          <= '0;
        res_status         <= (s_tuser == mcht_pkg::OP_QUERY && count == '0) ?
                              mcht_pkg::STATUS_EMPTY : mcht_pkg::STATUS_OK;
      end
      mcht_pkg::S_ADD_MUL_L: s2_line <= mem_rdata;
      mcht_pkg::S_ADD_MUL_R: lprod <= prod;
      mcht_pkg::S_ADD_CMP: begin
        if (redundant) begin
          top_line <= s2_line;
        end
      end
      mcht_pkg::S_ADD_FIN: begin
        if (same_slope) begin
          if (new_line.intercept < top_line.intercept) begin
            top_line.intercept <= new_line.intercept;
          end
        end else if (is_full) begin
          res_status <= mcht_pkg::STATUS_FULL;
        end else begin
          top_line <= new_line;
        end
      end
      mcht_pkg::S_Q_LOOP:    mid <= mid_c;
      mcht_pkg::S_Q_MID:     b_hold <= mem_rdata.intercept;
      mcht_pkg::S_Q_NEXT: begin
        val_mid <= prod[63:0] + 64'(b_hold);
        b_nx    <= mem_rdata.intercept;
      end
      mcht_pkg::S_Q_CMP: begin
        if (val_mid < val_nx) begin
          hi <= mid;
        end else begin
          lo <= mid + AW'(1);
        end
      end
      mcht_pkg::S_Q_FIN_MUL: b_hold <= mem_rdata.intercept;
      mcht_pkg::S_Q_FIN_ADD: res_value <= val_fin;
      default: begin
      end
    endcase
  end

  // Output register: loaded from the finished request once the previous
  // result has been taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == mcht_pkg::S_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == mcht_pkg::S_DONE && out_free) begin
      m_tdata <= {5'd0, mcht_pkg::COUNT_W'(count), res_value};
      m_tuser <= (op_r == mcht_pkg::OP_ADD || op_r == mcht_pkg::OP_QUERY) ?
                 res_status : mcht_pkg::STATUS_OK;
    end
  end

endmodule

`default_nettype wire

// ----- src/mcht_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Shared signed multiplier with a registered product.
module mcht_mul (
  input  wire logic               clk,
  input  wire logic signed [32:0] a,
  input  wire logic signed [32:0] b,
  output logic signed [65:0]      prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

`default_nettype wire

// ----- src/mcht_stack_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Line stack storage: one write port, one read port with registered data.
module mcht_stack_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [AW-1:0]         waddr,
  input  wire mcht_pkg::line_t       wdata,
  input  wire logic [AW-1:0]         raddr,
  output mcht_pkg::line_t            rdata
);

  mcht_pkg::line_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- src/mcht_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mcht_prop_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [1:0]  s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [79:0] m_tdata,
  input wire logic [1:0]  m_tuser
);

  // The unit works on one request at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while the previous one was still in work");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  a_flag_zero_value: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != mcht_pkg::STATUS_OK |-> m_tdata[63:0] == 64'd0)
    else $error("flagged result carries a nonzero value");

  // A clear leaves an empty envelope behind it.
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == mcht_pkg::OP_CLEAR && !m_tvalid
    |=> ##1 m_tvalid && m_tdata[74:64] == 11'd0 && m_tuser == mcht_pkg::STATUS_OK)
    else $error("clear did not report an empty envelope");

endmodule

bind monotone_convex_hull_trick_unit mcht_prop_checker u_mcht_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .s_tuser (s_tuser),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser)
);

`default_nettype wire

// ----- dv/mcht_checker.sv -----
`timescale 1ns / 1ps

module mcht_checker
  import mcht_pkg::*;
#(
  parameter int HULL_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [95:0] s_tdata,   // line_slope, line_intercept, query_x
  input  logic [1:0]  s_tuser,   // op
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [79:0] m_tdata,   // min_value, line_count, zero fill
  input  logic [1:0]  m_tuser,   // status
  output int          failures,
  output int          pending,
  output int          results_checked
);

  typedef struct packed {
    logic signed [63:0]  min_value;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  line_count;
  } envelope_result_t;

  logic signed [31:0] hull_slope     [HULL_DEPTH];
  logic signed [31:0] hull_intercept [HULL_DEPTH];
  int                 hull_count;
  envelope_result_t   expected_results [$];

  // The top line is covered when the new line takes over from it no later than
  // the line below it gives way. Both products are formed exactly at 66 bits.
  function automatic logic top_is_covered(int below, int top,
                                          logic signed [31:0] slope,
                                          logic signed [31:0] intercept);
    logic signed [32:0] rise_below, run_new, rise_new, run_below;
    logic signed [65:0] lhs, rhs;
    rise_below = hull_intercept[below] - hull_intercept[top];
    run_new    = slope - hull_slope[top];
    rise_new   = hull_intercept[top] - intercept;
    run_below  = hull_slope[top] - hull_slope[below];
    lhs = rise_below * run_new;
    rhs = rise_new * run_below;
    return lhs <= rhs;
  endfunction

  function automatic logic signed [63:0] value_at(int idx, logic signed [31:0] x);
    logic signed [63:0] wide_slope, wide_x, wide_intercept;
    wide_slope     = hull_slope[idx];
    wide_x         = x;
    wide_intercept = hull_intercept[idx];
    return wide_slope * wide_x + wide_intercept;
  endfunction

  function automatic envelope_result_t predict_request(logic [OP_W-1:0] op,
                                                       logic signed [31:0] slope,
                                                       logic signed [31:0] intercept,
                                                       logic signed [31:0] x);
    envelope_result_t r;
    int lo, hi, mid;
    r = '0;
    case (op)
      OP_ADD: begin
        while (hull_count >= 2 && hull_slope[hull_count-1] <= slope &&
               top_is_covered(hull_count - 2, hull_count - 1, slope, intercept))
          hull_count--;
        if (hull_count > 0 && hull_slope[hull_count-1] == slope) begin
          if (intercept < hull_intercept[hull_count-1])
            hull_intercept[hull_count-1] = intercept;
        end else if (hull_count >= HULL_DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          hull_slope[hull_count]     = slope;
          hull_intercept[hull_count] = intercept;
          hull_count++;
        end
      end
      OP_QUERY: begin
        if (hull_count == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          lo = 0;
          hi = hull_count - 1;
          while (lo != hi) begin
            mid = (lo + hi) / 2;
            if (value_at(mid, x) < value_at(mid + 1, x))
              hi = mid;
            else
              lo = mid + 1;
          end
          r.min_value = value_at(lo, x);
        end
      end
      OP_CLEAR: begin
        hull_count = 0;
      end
      default: ;
    endcase
    r.line_count = hull_count[COUNT_W-1:0];
    return r;
  endfunction

  // Appends one predicted result behind the ones still outstanding.
  task automatic record_expected(input envelope_result_t r);
    expected_results.insert(expected_results.size(), r);
  endtask

  always @(posedge clk) begin : monitor
    envelope_result_t got, want;
    if (rst) begin
      hull_count = 0;
      expected_results.delete();
      failures        = 0;
      results_checked = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.min_value  = m_tdata[63:0];
        got.line_count = m_tdata[74:64];
        got.status     = m_tuser;
        if (expected_results.size() == 0) begin
          if (failures < 10)
            $display("%0t: result with nothing outstanding: min_value %0d status %0d count %0d",
                     $realtime, got.min_value, got.status, got.line_count);
          failures++;
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (got.min_value !== want.min_value || got.status !== want.status ||
              got.line_count !== want.line_count) begin
            if (failures < 10) begin
              $display("%0t: result %0d mismatch: expected min_value %0d status %0d count %0d",
                       $realtime, results_checked, want.min_value, want.status,
                       want.line_count);
              $display("%0t: result %0d got min_value %0d status %0d count %0d",
                       $realtime, results_checked, got.min_value, got.status,
                       got.line_count);
            end
            failures++;
          end
        end
      end
      if (s_tvalid && s_tready)
        record_expected(predict_request(s_tuser, s_tdata[31:0],
                                        s_tdata[63:32], s_tdata[95:64]));
    end
    pending = expected_results.size();
  end

endmodule

// ----- dv/tb_monotone_convex_hull_trick_unit.sv -----
`timescale 1ns / 1ps

module tb_monotone_convex_hull_trick_unit;
  import mcht_pkg::*;

  localparam int              HULL_DEPTH = 1024;
  localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;
  localparam logic [31:0]     INT_MIN    = 32'h8000_0000;
  localparam logic [31:0]     INT_MAX    = 32'h7fff_ffff;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata  = '0;
  logic [1:0]  s_tuser  = OP_ADD;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;
  logic [1:0]  m_tuser;

  int failures, pending, results_checked;
  int add_count, query_count, clear_count, unused_count;
  bit steady = 1'b0;

  monotone_convex_hull_trick_unit #(
    .HULL_DEPTH(HULL_DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  mcht_checker #(
    .HULL_DEPTH(HULL_DEPTH)
  ) i_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tuser         (m_tuser),
    .failures        (failures),
    .pending         (pending),
    .results_checked (results_checked)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Mostly back to back, sometimes a short pause, rarely a long one.
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(99);
    if (steady || r < 65) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [31:0] pick_field();
    case ($urandom_range(9))
      0, 1, 2: return 32'(int'($urandom_range(100)) - 50);
      3, 4:    return 32'(int'($urandom_range(2_000_000)) - 1_000_000);
      5: begin
        case ($urandom_range(3))
          0:       return INT_MIN;
          1:       return INT_MAX;
          2:       return 32'd0;
          default: return 32'hffff_ffff;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return INT_MAX;
    if (v < -64'sd2147483648) return INT_MIN;
    return v[31:0];
  endfunction

  // Entered and left at a falling edge.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [31:0] slope,
                              input logic [31:0] intercept, input logic [31:0] x);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {x, intercept, slope};
    do @(posedge clk); while (!s_tready);
    case (op)
      OP_ADD:   add_count++;
      OP_QUERY: query_count++;
      OP_CLEAR: clear_count++;
      default:  unused_count++;
    endcase
    @(negedge clk);
  endtask

  initial begin : receiver
    int run, hold;
    forever begin
      run  = $urandom_range(20, 1);
      hold = idle_cycles();
      @(negedge clk) m_tready <= 1'b1;
      repeat (run - 1) @(negedge clk);
      if (hold > 0) begin
        @(negedge clk) m_tready <= 1'b0;
        repeat (hold - 1) @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    int     sent, n, k;
    longint slope_run;
    logic [31:0] step;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty envelope, unused op, equal slopes, extreme products,
    // out-of-order slopes and a middle line that gets popped.
    send_request(OP_QUERY, 32'd0, 32'd0, 32'd0);
    send_request(OP_UNUSED, INT_MAX, INT_MIN, INT_MAX);
    send_request(OP_ADD, INT_MIN, INT_MAX, 32'd0);
    send_request(OP_ADD, INT_MIN, INT_MIN, 32'd0);
    send_request(OP_ADD, INT_MIN, 32'd5, 32'd0);
    send_request(OP_QUERY, 32'd0, 32'd0, INT_MIN);
    send_request(OP_ADD, 32'd0, 32'd0, 32'd0);
    send_request(OP_ADD, INT_MAX, INT_MAX, 32'd0);
    send_request(OP_QUERY, 32'd0, 32'd0, INT_MIN);
    send_request(OP_QUERY, 32'd0, 32'd0, INT_MAX);
    send_request(OP_QUERY, 32'd0, 32'd0, 32'd0);
    send_request(OP_ADD, INT_MAX, INT_MIN, 32'd0);
    send_request(OP_ADD, 32'd5, 32'hffff_ffff, 32'd0);
    send_request(OP_QUERY, 32'hffff_ffff, 32'hffff_ffff, 32'd7);
    send_request(OP_CLEAR, INT_MAX, INT_MAX, INT_MAX);
    send_request(OP_QUERY, 32'd0, 32'd0, 32'd3);
    send_request(OP_CLEAR, 32'd0, 32'd0, 32'd0);
    send_request(OP_ADD, 32'hffff_ffff, 32'd0, 32'd0);
    send_request(OP_ADD, 32'd0, 32'd10, 32'd0);
    send_request(OP_ADD, 32'd1, 32'd0, 32'd0);
    send_request(OP_QUERY, 32'd0, 32'd0, 32'hffff_fffd);
    send_request(OP_QUERY, 32'd0, 32'd0, 32'd4);

    // Random: mostly runs of adds with nondecreasing slopes and queries mixed
    // in, the rest arbitrary requests.
    sent = 0;
    while (sent < 500) begin
      steady = ($urandom_range(7) == 0);
      if ($urandom_range(9) < 7) begin
        if ($urandom_range(1)) begin
          send_request(OP_CLEAR, pick_field(), pick_field(), pick_field());
          sent++;
        end
        n = $urandom_range(24, 1);
        slope_run = $signed(pick_field());
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(3) == 0) begin
            send_request(OP_QUERY, pick_field(), pick_field(), pick_field());
            sent++;
          end
          case ($urandom_range(9))
            0, 1, 2:    step = 32'd0;
            3, 4, 5, 6, 7: step = $urandom_range(100, 1);
            8:          step = $urandom_range(100_000, 1);
            default:    step = $urandom;
          endcase
          slope_run = $signed(clamp32(slope_run + longint'(step)));
          send_request(OP_ADD, slope_run[31:0], pick_field(), pick_field());
          sent++;
        end
        k = $urandom_range(4, 1);
        repeat (k) begin
          send_request(OP_QUERY, pick_field(), pick_field(), pick_field());
          sent++;
        end
      end else begin
        send_request(2'($urandom_range(3)), $urandom, $urandom, $urandom);
        sent++;
      end
    end

    // Fill the envelope: strictly falling slopes never pop, so every add pushes.
    steady = 1'b1;
    send_request(OP_CLEAR, 32'd0, 32'd0, 32'd0);
    for (int i = 0; i < HULL_DEPTH; i++)
      send_request(OP_ADD, 32'(2_000_000 - i * 1000), pick_field(), 32'd0);
    steady = 1'b0;
    send_request(OP_QUERY, 32'd0, 32'd0, 32'd0);
    send_request(OP_QUERY, 32'd0, 32'd0, INT_MAX);
    send_request(OP_QUERY, 32'd0, 32'd0, INT_MIN);
    send_request(OP_ADD, 32'(2_000_000 - (HULL_DEPTH - 1) * 1000), INT_MIN, 32'd0);
    send_request(OP_ADD, 32'(2_000_000 - (HULL_DEPTH - 1) * 1000), INT_MAX, 32'd0);
    send_request(OP_ADD, 32'd0, 32'd0, 32'd0);
    send_request(OP_ADD, INT_MIN, pick_field(), 32'd0);
    send_request(OP_ADD, INT_MAX, pick_field(), 32'd0);
    repeat (4) send_request(OP_QUERY, 32'd0, 32'd0, pick_field());
    send_request(OP_CLEAR, 32'd0, 32'd0, 32'd0);
    send_request(OP_QUERY, 32'd0, 32'd0, pick_field());
    s_tvalid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (16) @(negedge clk);

    $display("Checked %0d results from %0d adds, %0d queries, %0d clears, %0d unused ops.",
             results_checked, add_count, query_count, clear_count, unused_count);
    $display("Envelope taken up to %0d lines, with dropped adds and empty queries.",
             HULL_DEPTH);
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
